>>> rtl/core/sar_pkg.sv
package sar_pkg;

    // Default stack size and pstr walk limit
    localparam int STACK_DEPTH_DEF = 32;
    localparam int PSTR_MAX        = 32;
    localparam int WALK_W          = 6;

    localparam int WORD_W = 32;

    // Character bounds
    localparam logic [WORD_W-1:0] CHAR_LOW  = 32'd32;
    localparam logic [WORD_W-1:0] CHAR_HIGH = 32'd127;
    localparam logic [6:0]        NEWLINE   = 7'd10;

    // Action codes
    localparam logic [2:0] ACT_PUSH  = 3'd0;
    localparam logic [2:0] ACT_MUL   = 3'd1;
    localparam logic [2:0] ACT_MOD   = 3'd2;
    localparam logic [2:0] ACT_PCHAR = 3'd3;
    localparam logic [2:0] ACT_PSTR  = 3'd4;
    localparam logic [2:0] ACT_ROTL  = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_SHORT = 3'd1;
    localparam logic [2:0] ERR_DIV0  = 3'd2;
    localparam logic [2:0] ERR_EMPTY = 3'd3;
    localparam logic [2:0] ERR_RANGE = 3'd4;
    localparam logic [2:0] ERR_FULL  = 3'd5;

    // Read address select
    localparam logic [1:0] RD_TOP    = 2'd0;
    localparam logic [1:0] RD_SECOND = 2'd1;
    localparam logic [1:0] RD_WALK   = 2'd2;

    // Write select
    localparam logic [1:0] WR_PUSH = 2'd0;
    localparam logic [1:0] WR_MUL  = 2'd1;
    localparam logic [1:0] WR_REM  = 2'd2;
    localparam logic [1:0] WR_ROTL = 2'd3;

    // Character source for an emitted item
    localparam logic [1:0] CHR_NONE = 2'd0;
    localparam logic [1:0] CHR_WORD = 2'd1;
    localparam logic [1:0] CHR_NL   = 2'd2;

    typedef struct packed {
        logic       latch;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       ld_b;
        logic       ld_a;
        logic       mul_ld;
        logic       div_start;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       walk_clr;
        logic       walk_inc;
        logic       emit;
        logic [1:0] kind;
        logic [1:0] chr_src;
        logic [2:0] err;
        logic       last;
    } sar_cmd_t;

    typedef struct packed {
        logic full;
        logic lt2;
        logic empty;
        logic out_free;
        logic top_print;
        logic walk_char;
        logic b_zero;
        logic div_done;
        logic walk_end;
    } sar_status_t;

endpackage

>>> rtl/core/stack_alu_with_rotate_unit.sv
// Push, unused actions and the stack-depth errors emit from the execute state; rotl,
// pchar and mul read the stack first; mod waits on the one-bit-a-cycle remainder unit.
// pstr: each character goes through the single stack read port, plus the newline.
// One item is worked at a time; the next is taken once the last result is registered.
// Reset (synchronous, active low) empties the stack and clears the output valid;
// stack contents are not cleared.
module stack_alu_with_rotate_unit
    import sar_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_action,
    input  logic signed [31:0] s_push_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [6:0]         m_char_code,
    output logic [2:0]         m_error_code,
    output logic               m_last
);

    sar_cmd_t    cmd;
    sar_status_t status;

    sar_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .status   (status),
        .cmd      (cmd)
    );

    sar_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_push_value (s_push_value),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_char_code  (m_char_code),
        .m_error_code (m_error_code),
        .m_last       (m_last)
    );

endmodule

>>> rtl/core/sar_datapath.sv
module sar_datapath
    import sar_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic signed [31:0] s_push_value,
    input  sar_cmd_t           cmd,
    output sar_status_t        status,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [6:0]         m_char_code,
    output logic [2:0]         m_error_code,
    output logic               m_last
);

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int PW    = (CNT_W > WALK_W) ? CNT_W : WALK_W;

    logic [WORD_W-1:0] mem [STACK_DEPTH];

    logic [IDX_W-1:0]  bottom_reg, bottom_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WALK_W-1:0] walk_reg, walk_next;
    logic [WORD_W-1:0] val_reg;
    logic [WORD_W-1:0] rd_reg;
    logic [WORD_W-1:0] a_reg, b_reg, prod_reg;

    logic [WORD_W-1:0] dvd_reg, dsr_reg, rem_reg;
    logic              neg_reg;
    logic [5:0]        div_cnt_reg;

    logic              m_valid_reg;
    logic [1:0]        kind_reg;
    logic [6:0]        char_reg;
    logic [2:0]        err_reg;
    logic              last_reg;

    logic [PW-1:0]     cnt_ext, walk_ext;
    logic [PW-1:0]     top_pos, sec_pos, walk_pos;
    logic [IDX_W-1:0]  rd_addr, wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] rem_fix;
    logic [32:0]       div_shift, div_diff;
    logic [6:0]        emit_char;
    logic              out_free;

    // Map a position counted from the bottom to its slot
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] bot,
                                                 input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, bot} + {1'b0, pos};
        if (sum >= (IDX_W+1)'(STACK_DEPTH)) begin
            sum = sum - (IDX_W+1)'(STACK_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Positions of top, second and current walk entry
    always_comb begin
        cnt_ext  = PW'(count_reg);
        walk_ext = PW'(walk_reg);
        top_pos  = cnt_ext - PW'(1);
        sec_pos  = cnt_ext - PW'(2);
        walk_pos = cnt_ext - PW'(1) - walk_ext;
    end

    // Select read address
    always_comb begin
        case (cmd.rd_sel)
            RD_TOP:    rd_addr = slot_of(bottom_reg, top_pos[IDX_W-1:0]);
            RD_SECOND: rd_addr = slot_of(bottom_reg, sec_pos[IDX_W-1:0]);
            RD_WALK:   rd_addr = slot_of(bottom_reg, walk_pos[IDX_W-1:0]);
            default:   rd_addr = slot_of(bottom_reg, top_pos[IDX_W-1:0]);
        endcase
    end

    // Select write address, data and stack pointer updates
    always_comb begin
        rem_fix     = neg_reg ? (WORD_W'(0) - rem_reg) : rem_reg;
        bottom_next = bottom_reg;
        count_next  = count_reg;
        case (cmd.wr_sel)
            WR_PUSH: begin
                wr_addr    = slot_of(bottom_reg, cnt_ext[IDX_W-1:0]);
                wr_data    = val_reg;
                count_next = count_reg + CNT_W'(1);
            end
            WR_MUL: begin
                wr_addr    = slot_of(bottom_reg, sec_pos[IDX_W-1:0]);
                wr_data    = prod_reg;
                count_next = count_reg - CNT_W'(1);
            end
            WR_REM: begin
                wr_addr    = slot_of(bottom_reg, sec_pos[IDX_W-1:0]);
                wr_data    = rem_fix;
                count_next = count_reg - CNT_W'(1);
            end
            default: begin
                if (bottom_reg == '0) begin
                    bottom_next = IDX_W'(STACK_DEPTH - 1);
                end else begin
                    bottom_next = bottom_reg - IDX_W'(1);
                end
                wr_addr = bottom_next;
                wr_data = rd_reg;
            end
        endcase
    end

    // Stack storage: one write and one registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Stack pointers and walk index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bottom_reg <= '0;
            count_reg  <= '0;
            walk_reg   <= '0;
        end else begin
            if (cmd.wr_en) begin
                bottom_reg <= bottom_next;
                count_reg  <= count_next;
            end
            walk_reg <= walk_next;
        end
    end

    always_comb begin
        walk_next = walk_reg;
        if (cmd.walk_clr) begin
            walk_next = '0;
        end else if (cmd.walk_inc) begin
            walk_next = walk_reg + WALK_W'(1);
        end
    end

    // Operands and product
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            val_reg <= $unsigned(s_push_value);
        end
        if (cmd.ld_b) begin
            b_reg <= rd_reg;
        end
        if (cmd.ld_a) begin
            a_reg <= rd_reg;
        end
        if (cmd.mul_ld) begin
            prod_reg <= WORD_W'(a_reg * b_reg);
        end
    end

    // Restoring remainder on magnitudes, one bit a cycle
    always_comb begin
        div_shift = {rem_reg, dvd_reg[WORD_W-1]};
        div_diff  = div_shift - {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_start) begin
            div_cnt_reg <= 6'(WORD_W);
        end else if (div_cnt_reg != '0) begin
            div_cnt_reg <= div_cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            neg_reg <= rd_reg[WORD_W-1];
            dvd_reg <= rd_reg[WORD_W-1] ? (WORD_W'(0) - rd_reg) : rd_reg;
            dsr_reg <= b_reg[WORD_W-1] ? (WORD_W'(0) - b_reg) : b_reg;
            rem_reg <= '0;
        end else if (div_cnt_reg != '0) begin
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
            rem_reg <= div_diff[32] ? div_shift[WORD_W-1:0] : div_diff[WORD_W-1:0];
        end
    end

    // Output register
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        case (cmd.chr_src)
            CHR_WORD: emit_char = rd_reg[6:0];
            CHR_NL:   emit_char = NEWLINE;
            default:  emit_char = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            kind_reg <= cmd.kind;
            char_reg <= emit_char;
            err_reg  <= cmd.err;
            last_reg <= cmd.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = kind_reg;
    assign m_char_code  = char_reg;
    assign m_error_code = err_reg;
    assign m_last       = last_reg;

    // Status toward the controller
    always_comb begin
        status.full      = (count_reg == CNT_W'(STACK_DEPTH));
        status.lt2       = (count_reg < CNT_W'(2));
        status.empty     = (count_reg == '0);
        status.out_free  = out_free;
        status.top_print = (rd_reg >= CHAR_LOW) && (rd_reg <= CHAR_HIGH);
        status.walk_char = (rd_reg != '0) && (rd_reg <= CHAR_HIGH);
        status.b_zero    = (b_reg == '0);
        status.div_done  = (div_cnt_reg == '0);
        status.walk_end  = (walk_ext >= cnt_ext) || (walk_reg == WALK_W'(PSTR_MAX));
    end

endmodule

>>> rtl/core/sar_ctrl.sv
module sar_ctrl
    import sar_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  sar_status_t status,
    output sar_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EXEC  = 4'd1;
    localparam logic [3:0] ST_RD1   = 4'd2;
    localparam logic [3:0] ST_RD2   = 4'd3;
    localparam logic [3:0] ST_MULR  = 4'd4;
    localparam logic [3:0] ST_MULW  = 4'd5;
    localparam logic [3:0] ST_DIVR  = 4'd6;
    localparam logic [3:0] ST_DIVW  = 4'd7;
    localparam logic [3:0] ST_PCHK  = 4'd8;
    localparam logic [3:0] ST_NL    = 4'd9;
    localparam logic [3:0] ST_PSRD  = 4'd10;
    localparam logic [3:0] ST_PSCHK = 4'd11;
    localparam logic [3:0] ST_ROTW  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [2:0] action_reg, action_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            action_reg <= ACT_PUSH;
        end else begin
            state_reg  <= state_next;
            action_reg <= action_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && aresetn;

    // Sequence one item through the datapath
    always_comb begin
        state_next  = state_reg;
        action_next = action_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch   = 1'b1;
                    action_next = s_action;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (action_reg)
                    ACT_PUSH: begin
                        if (status.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            state_next = ST_IDLE;
                            if (status.full) begin
                                cmd.kind = KIND_ERR;
                                cmd.err  = ERR_FULL;
                            end else begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_sel = WR_PUSH;
                                cmd.kind   = KIND_ACK;
                            end
                        end
                    end
                    ACT_MUL, ACT_MOD: begin
                        if (!status.lt2) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_TOP;
                            state_next = ST_RD1;
                        end else if (status.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.kind   = KIND_ERR;
                            cmd.err    = ERR_SHORT;
                            cmd.last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    ACT_PCHAR: begin
                        if (!status.empty) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_TOP;
                            state_next = ST_PCHK;
                        end else if (status.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.kind   = KIND_ERR;
                            cmd.err    = ERR_EMPTY;
                            cmd.last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    ACT_PSTR: begin
                        cmd.walk_clr = 1'b1;
                        state_next   = ST_PSRD;
                    end
                    ACT_ROTL: begin
                        if (!status.lt2) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_TOP;
                            state_next = ST_ROTW;
                        end else if (status.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.kind   = KIND_ACK;
                            cmd.last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default: begin
                        // Unused actions: acknowledge only
                        if (status.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.kind   = KIND_ACK;
                            cmd.last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_RD1: begin
                cmd.ld_b   = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SECOND;
                state_next = ST_RD2;
            end
            ST_RD2: begin
                if (action_reg == ACT_MUL) begin
                    cmd.ld_a   = 1'b1;
                    state_next = ST_MULR;
                end else if (!status.b_zero) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVR;
                end else if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_ERR;
                    cmd.err    = ERR_DIV0;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MULR: begin
                cmd.mul_ld = 1'b1;
                state_next = ST_MULW;
            end
            ST_MULW: begin
                if (status.out_free) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_MUL;
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_ACK;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIVR: begin
                if (status.div_done) begin
                    state_next = ST_DIVW;
                end
            end
            ST_DIVW: begin
                if (status.out_free) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_REM;
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_ACK;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PCHK: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.top_print) begin
                        cmd.kind    = KIND_CHAR;
                        cmd.chr_src = CHR_WORD;
                        state_next  = ST_NL;
                    end else begin
                        cmd.kind   = KIND_ERR;
                        cmd.err    = ERR_RANGE;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NL: begin
                if (status.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = KIND_CHAR;
                    cmd.chr_src = CHR_NL;
                    cmd.last    = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_PSRD: begin
                if (status.walk_end) begin
                    state_next = ST_NL;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_WALK;
                    state_next = ST_PSCHK;
                end
            end
            ST_PSCHK: begin
                // Stop the walk at zero or a non-ASCII word
                if (!status.walk_char) begin
                    state_next = ST_NL;
                end else if (status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.kind     = KIND_CHAR;
                    cmd.chr_src  = CHR_WORD;
                    cmd.walk_inc = 1'b1;
                    state_next   = ST_PSRD;
                end
            end
            ST_ROTW: begin
                if (status.out_free) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_ROTL;
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_ACK;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/sar_checker.sv
module sar_checker
    import sar_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [6:0]  m_char_code,
    input logic [2:0]  m_error_code,
    input logic        m_last
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_char_code)
            && $stable(m_error_code) && $stable(m_last))
        else $error("stalled result item changed");

    // Take no new item right after one is accepted
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted back to back");

    // Close an error or acknowledge with last and zero unused fields
    a_err_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ERR |-> m_last && m_char_code == '0
            && m_error_code != ERR_NONE)
        else $error("malformed error item");

    a_ack_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ACK |-> m_last && m_char_code == '0
            && m_error_code == ERR_NONE)
        else $error("malformed acknowledge item");

    // Character items carry no error and end on a newline
    a_char_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_CHAR |-> m_error_code == ERR_NONE
            && (!m_last || m_char_code == NEWLINE))
        else $error("malformed character item");

endmodule

bind stack_alu_with_rotate_unit sar_checker u_sar_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_char_code  (m_char_code),
    .m_error_code (m_error_code),
    .m_last       (m_last)
);
